@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // Decoder state, one-hot encoded.
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_ESCAPE = 6'b000010,
        MODE_HEX1   = 6'b000100,
        MODE_HEX2   = 6'b001000,
        MODE_HEX3   = 6'b010000,
        MODE_HEX4   = 6'b100000
    } mode_t;

    // Span status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ESC = 2'd1,
        ST_BAD_HEX = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded work unit: up to three bytes and an optional done result.
    typedef struct packed {
        logic [1:0] nbytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       done;
        status_t    status;
    } job_t;

    // Hex digit decode: {is_hex, value}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, runs the escape decoder and emits at most one job per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_has_byte,
    input  wire logic [7:0]   in_data_byte,
    input  wire logic         in_end,
    input  wire logic         queue_full,
    output logic              in_ready,
    output logic              push,
    output jsu_pkg::job_t     job
);
    import jsu_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [11:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;
    status_t     err_reg, err_next;

    logic [4:0]  nib;
    logic [15:0] cp;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign nib      = hex_nibble(in_data_byte);
    assign cp       = {acc_reg, nib[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        err_next   = err_reg;
        job        = '0;
        job.status = ST_OK;

        if (in_has_byte && err_reg == ST_OK) begin
            case (mode_reg)
                MODE_ESCAPE:
                begin
                    mode_next  = MODE_NORMAL;
                    job.nbytes = 2'd1;
                    case (in_data_byte)
                        CH_QUOTE:     job.byte0 = CH_QUOTE;
                        CH_BACKSLASH: job.byte0 = CH_BACKSLASH;
                        CH_SLASH:     job.byte0 = CH_SLASH;
                        CH_B:         job.byte0 = 8'h08;
                        CH_F:         job.byte0 = 8'h0C;
                        CH_N:         job.byte0 = 8'h0A;
                        CH_R:         job.byte0 = 8'h0D;
                        CH_T:         job.byte0 = 8'h09;
                        CH_U:
                        begin
                            job.nbytes = 2'd0;
                            mode_next  = MODE_HEX1;
                            acc_next   = '0;
                            bad_next   = 1'b0;
                        end
                        default:
                        begin
                            job.nbytes = 2'd0;
                            err_next   = ST_BAD_ESC;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3:
                begin
                    acc_next  = {acc_reg[7:0], nib[3:0]};
                    bad_next  = bad_reg | !nib[4];
                    mode_next = mode_t'({mode_reg[4:0], 1'b0});
                end
                MODE_HEX4:
                begin
                    mode_next = MODE_NORMAL;
                    acc_next  = '0;
                    bad_next  = 1'b0;
                    if (bad_reg || !nib[4]) begin
                        err_next = ST_BAD_HEX;
                    end else if (cp[15:7] == '0) begin
                        job.nbytes = 2'd1;
                        job.byte0  = cp[7:0];
                    end else if (cp[15:11] == '0) begin
                        job.nbytes = 2'd2;
                        job.byte0  = UTF8_LEAD2 | {3'b0, cp[10:6]};
                        job.byte1  = UTF8_CONT  | {2'b0, cp[5:0]};
                    end else begin
                        job.nbytes = 2'd3;
                        job.byte0  = UTF8_LEAD3 | {4'b0, cp[15:12]};
                        job.byte1  = UTF8_CONT  | {2'b0, cp[11:6]};
                        job.byte2  = UTF8_CONT  | {2'b0, cp[5:0]};
                    end
                end
                default:
                begin
                    // Normal mode; also the fallback for any unexpected code.
                    mode_next = MODE_NORMAL;
                    if (in_data_byte == CH_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        job.nbytes = 2'd1;
                        job.byte0  = in_data_byte;
                    end
                end
            endcase
        end

        if (in_end) begin
            job.done   = 1'b1;
            job.status = err_next;
            if (err_next == ST_OK && mode_next != MODE_NORMAL) begin
                job.status = ST_TRUNC;
            end
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            bad_next  = 1'b0;
            err_next  = ST_OK;
        end
    end

    assign push = accept && (job.nbytes != 2'd0 || job.done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            bad_reg  <= 1'b0;
            err_reg  <= ST_OK;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            bad_reg  <= bad_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue
// Small job FIFO that decouples the decoder from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output jsu_pkg::job_t      head
);
    import jsu_pkg::*;

    job_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = do_pop  ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Walks each queued job and presents its results one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire jsu_pkg::job_t job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_byte_valid,
    output logic               out_done,
    output logic [1:0]         out_status,
    output logic               out_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       bv_reg, done_reg, last_reg;
    status_t    status_reg;

    logic       load, is_byte, is_last;
    logic [7:0] cur_byte;

    assign load    = job_valid && (!valid_reg || out_ready);
    assign is_byte = (idx_reg < job.nbytes);
    assign is_last = job.done ? !is_byte : (idx_reg == job.nbytes - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = job.byte0;
            2'd1:    cur_byte = job.byte1;
            2'd2:    cur_byte = job.byte2;
            default: cur_byte = '0;
        endcase

        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end

        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= is_byte ? cur_byte : 8'h00;
            bv_reg     <= is_byte;
            done_reg   <= !is_byte;
            status_reg <= is_byte ? ST_OK : job.status;
            last_reg   <= is_last;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bv_reg;
    assign out_done       = done_reg;
    assign out_status     = status_reg;
    assign out_last       = last_reg;

endmodule

`default_nettype wire

@@ rtl/json_string_unescape.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body unescaper with UTF-8 output for backslash-u escapes.
// ----------------------------------------------------------------------------
// Usage: raw bytes of a string body arrive on the s_axis channel, one per
// beat. s_axis_tuser marks whether s_axis_tdata holds a byte, and s_axis_tlast
// ends the span. Decoded bytes leave on m_axis, one result per beat; the span
// end produces a done beat (m_axis_tuser[1]) carrying the status in
// m_axis_tdata[9:8]. m_axis_tlast is set on the final beat caused by one
// input beat. One input beat yields zero to four output beats.
// Throughput: one input beat per cycle while the job queue has room; the
// output side drives one beat per cycle while m_axis_tready is high, so
// a backslash-u escape that expands to three UTF-8 bytes takes three beats
// and the four-deep queue absorbs the difference before s_axis_tready falls.
// Path: with nothing queued ahead, the first result of an input beat is
// written into the job queue at the edge that accepts it, and the output
// register then loads it from the queue head.
// Reset clears the decoder state, the queue and the output valid flag; no beat
// is presented until new input arrives. When the receiver holds m_axis_tready
// low, the output beat holds, the queue fills and the input side then stalls;
// decoder state is never lost.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_span
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [9:8] status, rest zero
    output logic [1:0]       m_axis_tuser,   // [0] byte_valid, [1] string_done
    output logic             m_axis_tlast    // last_of_run
);
    import jsu_pkg::*;

    job_t       push_job, head_job;
    logic       push, pop, q_full, q_not_empty;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       out_bv, out_done;

    // Front end: decoder state machine, at most one job per accepted beat.
    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_has_byte  (s_axis_tuser[0]),
        .in_data_byte (s_axis_tdata),
        .in_end       (s_axis_tlast),
        .queue_full   (q_full),
        .in_ready     (s_axis_tready),
        .push         (push),
        .job          (push_job)
    );

    // Job queue between decoder and sequencer.
    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    // Back end: expands each job into result beats.
    jsu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (q_not_empty),
        .job            (head_job),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (out_byte),
        .out_byte_valid (out_bv),
        .out_done       (out_done),
        .out_status     (out_status),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_status, out_byte};
    assign m_axis_tuser = {out_done, out_bv};

`ifndef SYNTHESIS
    // Every presented beat is either a byte or a done result, never both.
    a_kind_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tuser))
        else $error("output beat kind is not one-hot");

    // A done result always closes the run of its input beat.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("done beat without last_of_run");

    // Byte results carry a zero status.
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[9:8] == 2'd0))
        else $error("byte beat with nonzero status");

    // A job leaves the queue only while the output stage takes a beat.
    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("queue popped without a presented beat");
`endif

endmodule

`default_nettype wire
